>>> src/vcx_pkg.sv
// shared constants, types and codes for the vram color expand and row transfer block
package vcx_pkg;

  // memory geometry: bytes are stored sixteen to a word
  localparam int unsigned MEM_BYTES  = 524288;
  localparam int unsigned ADDR_W     = $clog2(MEM_BYTES);
  localparam int unsigned WORD_BYTES = 16;
  localparam int unsigned WORD_BITS  = 8 * WORD_BYTES;
  localparam int unsigned LANE_W     = $clog2(WORD_BYTES);
  localparam int unsigned WORD_AW    = ADDR_W - LANE_W;
  localparam int unsigned MEM_WORDS  = MEM_BYTES / WORD_BYTES;

  // processor address windows
  localparam logic [31:0] BIT_WIN_LO  = 32'h0200_0000;
  localparam logic [31:0] BIT_WIN_HI  = 32'h020f_ffff;
  localparam logic [31:0] BYTE_WIN_LO = 32'hff80_0000;
  localparam int unsigned BYTE_SHIFT  = 3;

  // row sizes in words
  localparam int unsigned BIT_ROW_WORDS  = (512 * 8) / WORD_BYTES;
  localparam int unsigned BYTE_ROW_WORDS = (511 + 1) / WORD_BYTES;
  localparam int unsigned BUF_AW         = $clog2(BIT_ROW_WORDS);
  localparam int unsigned LEN_W          = BUF_AW + 1;

  typedef logic [WORD_BITS-1:0] word_t;

  typedef enum logic [2:0] {
    OP_EXPAND1  = 3'd0,
    OP_EXPAND2  = 3'd1,
    OP_SELECT   = 3'd2,
    OP_TRANSFER = 3'd3,
    OP_READ     = 3'd4
  } opcode_t;

  typedef enum logic [1:0] {
    STAT_DONE     = 2'd0,
    STAT_OUTSIDE  = 2'd1,
    STAT_DISABLED = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CFG_MULTISYNC = 2'd0,
    CFG_FILL      = 2'd1,
    CFG_XFER_EN   = 2'd2
  } cfg_index_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MERGE,
    S_COPY_IN,
    S_COPY_OUT,
    S_FINISH
  } state_t;

  // decoded row from a processor bit address
  typedef struct packed {
    logic               hit;
    logic [WORD_AW-1:0] start;
    logic [LEN_W-1:0]   len;
  } row_dec_t;

endpackage

>>> src/vcx_if.sv
// handshake channels: command, response and configuration write
interface vcx_cmd_if import vcx_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [2:0]  opcode;
  logic [31:0] bus_address;
  logic [15:0] group_offset;
  logic [15:0] pixel_pattern;
  logic [18:0] read_address;

  modport source (output valid, opcode, bus_address, group_offset, pixel_pattern,
                  read_address, input ready);
  modport sink   (input valid, opcode, bus_address, group_offset, pixel_pattern,
                  read_address, output ready);
endinterface

interface vcx_rsp_if import vcx_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] read_byte;
  logic [1:0] status;

  modport source (output valid, read_byte, status, input ready);
  modport sink   (input valid, read_byte, status, output ready);
endinterface

interface vcx_cfg_if import vcx_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> src/vcx_ram.sv
// generic simple dual-port ram with registered read
module vcx_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/vcx_row_decode.sv
// maps a processor bit-window or byte-window address to an aligned row start and length in words
module vcx_row_decode import vcx_pkg::*; (
  input  logic [31:0] bus_address,
  input  logic        mode,
  output row_dec_t    dec
);

  logic [31:0]        off_bit;
  logic [31:0]        off_byte;
  logic [31:0]        b_bit;
  logic [31:0]        b_byte;
  logic [LEN_W-1:0]   len_bit;
  logic [WORD_AW-1:0] mask_bit;
  logic [WORD_AW-1:0] w_bit;
  logic [WORD_AW-1:0] w_byte;
  logic               in_bit;
  logic               in_byte;

  always_comb begin
    in_bit   = (bus_address >= BIT_WIN_LO) && (bus_address <= BIT_WIN_HI);
    in_byte  = (bus_address >= BYTE_WIN_LO);
    off_bit  = bus_address - BIT_WIN_LO;
    off_byte = bus_address - BYTE_WIN_LO;
    // multisync halves both the address scale and the row
    b_bit    = off_bit >> mode;
    b_byte   = off_byte >> BYTE_SHIFT;
    len_bit  = LEN_W'(BIT_ROW_WORDS) >> mode;
    mask_bit = ~(WORD_AW'(len_bit) - WORD_AW'(1));
    w_bit    = b_bit[ADDR_W-1:LANE_W] & mask_bit;
    w_byte   = b_byte[ADDR_W-1:LANE_W] & ~WORD_AW'(BYTE_ROW_WORDS - 1);

    dec.hit   = in_bit || in_byte;
    dec.start = in_bit ? w_bit : w_byte;
    dec.len   = in_bit ? len_bit : LEN_W'(BYTE_ROW_WORDS);
  end

endmodule

>>> src/vram_color_expand_and_row_transfer.sv
// top level: byte video memory with color expand writes, row transfers and byte reads
// flow: expand and read ops go from accept through the merge step to finish,
//   select and rejected ops straight to finish; a row transfer reads len 16-byte
//   words (256, 128 or 32) into the row buffer, then writes them to the destination
// throughput: one command at a time; the next command is taken once the current
//   result sits in the output register, even if that result is not yet taken
// reset: clears fsm, config registers and the latched source row; memory contents
//   are undefined until written and get no clearing pass
module vram_color_expand_and_row_transfer import vcx_pkg::*; (
  input logic       clk,
  input logic       rst,
  vcx_cmd_if.sink   cmd,
  vcx_rsp_if.source rsp,
  vcx_cfg_if.sink   cfg
);

  // fsm
  state_t state;
  state_t state_next;

  // config registers
  logic        mode;
  logic [15:0] fill;
  logic        xfer_en;

  // latched source row start, in words
  logic [WORD_AW-1:0] source_row;

  // per-command working registers
  logic [2:0]         op_code;
  logic [WORD_AW-1:0] op_word;
  logic [15:0]        op_pattern;
  logic               op_half;
  logic [LANE_W-1:0]  op_sel;
  logic [7:0]         res_byte;
  status_t            res_status;
  status_t            acc_status;
  logic [WORD_AW-1:0] xfer_dst;
  logic [LEN_W-1:0]   xfer_len;

  // row walk counter and the registered index of the read in flight
  logic [LEN_W-1:0]  cnt;
  logic              pend_valid;
  logic [BUF_AW-1:0] pend_idx;

  // output register
  logic       out_valid;
  logic [7:0] out_byte;
  logic [1:0] out_status;

  // memory ports
  logic               mem_we;
  logic [WORD_AW-1:0] mem_waddr;
  word_t              mem_wdata;
  logic [WORD_AW-1:0] mem_raddr;
  word_t              mem_rdata;
  logic               buf_we;
  logic [BUF_AW-1:0]  buf_raddr;
  word_t              buf_rdata;

  logic [WORD_AW-1:0] in_word;
  logic [31:0]        g32;
  logic [31:0]        r32;
  word_t              merged;
  row_dec_t           dec;
  logic               accept;
  logic               walking;
  logic               walk_end;
  logic               out_free;

  assign accept   = cmd.valid && cmd.ready;
  assign walking  = (state == S_COPY_IN) || (state == S_COPY_OUT);
  assign walk_end = (cnt == xfer_len);
  assign out_free = !out_valid || rsp.ready;

  assign cmd.ready     = (state == S_IDLE);
  assign cfg.ready     = 1'b1;
  assign rsp.valid     = out_valid;
  assign rsp.read_byte = out_byte;
  assign rsp.status    = out_status;

  vcx_row_decode u_decode (
    .bus_address (cmd.bus_address),
    .mode        (mode),
    .dec         (dec)
  );

  // pixel memory, one 16-byte word per entry
  vcx_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (MEM_WORDS)
  ) u_pixel_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // row buffer: the whole source row lands here before any destination write
  vcx_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (BIT_ROW_WORDS)
  ) u_row_buf (
    .clk   (clk),
    .we    (buf_we),
    .waddr (pend_idx),
    .wdata (mem_rdata),
    .raddr (buf_raddr),
    .rdata (buf_rdata)
  );

  // word addressed by an incoming expand or read command, wrapped to memory size
  always_comb begin
    g32 = {16'b0, cmd.group_offset};
    r32 = {13'b0, cmd.read_address};
    case (cmd.opcode)
      OP_EXPAND1: in_word = g32[WORD_AW-1:0];
      OP_EXPAND2: in_word = g32[WORD_AW:1];
      OP_READ:    in_word = r32[ADDR_W-1:LANE_W];
      default:    in_word = '0;
    endcase
  end

  // status decided at accept time
  always_comb begin
    acc_status = STAT_DONE;
    if (cmd.opcode == OP_SELECT) begin
      if (!dec.hit) begin
        acc_status = STAT_OUTSIDE;
      end
    end else if (cmd.opcode == OP_TRANSFER) begin
      if (!xfer_en) begin
        acc_status = STAT_DISABLED;
      end else if (!dec.hit) begin
        acc_status = STAT_OUTSIDE;
      end
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (cmd.valid) begin
          unique case (cmd.opcode)
            OP_EXPAND1, OP_EXPAND2, OP_READ: state_next = S_MERGE;
            OP_TRANSFER: begin
              state_next = (xfer_en && dec.hit) ? S_COPY_IN : S_FINISH;
            end
            default: state_next = S_FINISH;
          endcase
        end
      end
      S_MERGE: state_next = S_FINISH;
      S_COPY_IN: begin
        if (walk_end) begin
          state_next = S_COPY_OUT;
        end
      end
      S_COPY_OUT: begin
        if (walk_end) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // expand merge: fill color into the bytes the pattern selects
  always_comb begin
    merged = mem_rdata;
    if (op_code == OP_EXPAND1) begin
      for (int k = 0; k < 16; k++) begin
        if (op_pattern[k]) begin
          merged[8*k +: 8] = fill[7:0];
        end
      end
    end else begin
      // 2bpp: even pattern bits only, alternating color bytes
      for (int j = 0; j < 8; j++) begin
        if (op_pattern[2*j]) begin
          if (op_half) begin
            merged[8*(j+8) +: 8] = fill[8*(j%2) +: 8];
          end else begin
            merged[8*j +: 8] = fill[8*(j%2) +: 8];
          end
        end
      end
    end
  end

  // fsm outputs: memory and buffer controls
  always_comb begin
    mem_raddr = in_word;
    mem_we    = 1'b0;
    mem_waddr = op_word;
    mem_wdata = merged;
    buf_we    = 1'b0;
    buf_raddr = cnt[BUF_AW-1:0];
    unique case (state)
      S_MERGE: begin
        mem_we = (op_code == OP_EXPAND1) || (op_code == OP_EXPAND2);
      end
      S_COPY_IN: begin
        // source wraps past the end of memory by address truncation
        mem_raddr = source_row + WORD_AW'(cnt);
        buf_we    = pend_valid;
      end
      S_COPY_OUT: begin
        mem_we    = pend_valid;
        mem_waddr = xfer_dst + WORD_AW'(pend_idx);
        mem_wdata = buf_rdata;
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      mode       <= 1'b0;
      fill       <= '0;
      xfer_en    <= 1'b0;
      source_row <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      pend_valid <= walking && !walk_end;
      if (cfg.valid) begin
        unique case (cfg.index)
          CFG_MULTISYNC: mode    <= cfg.data[0];
          CFG_FILL:      fill    <= cfg.data;
          CFG_XFER_EN:   xfer_en <= cfg.data[0];
          default: begin
          end
        endcase
      end
      if (accept && (cmd.opcode == OP_SELECT) && dec.hit) begin
        source_row <= dec.start;
      end
      if ((state == S_FINISH) && out_free) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    pend_idx <= cnt[BUF_AW-1:0];
    if (accept) begin
      op_code    <= cmd.opcode;
      op_word    <= in_word;
      op_pattern <= cmd.pixel_pattern;
      op_half    <= cmd.group_offset[0];
      op_sel     <= cmd.read_address[LANE_W-1:0];
      res_byte   <= '0;
      res_status <= acc_status;
      xfer_dst   <= dec.start;
      xfer_len   <= dec.len;
      cnt        <= '0;
    end
    if ((state == S_MERGE) && (op_code == OP_READ)) begin
      res_byte <= mem_rdata[{op_sel, 3'b000} +: 8];
    end
    if (walking) begin
      cnt <= walk_end ? '0 : cnt + LEN_W'(1);
    end
    if ((state == S_FINISH) && out_free) begin
      out_byte   <= res_byte;
      out_status <= res_status;
    end
  end

  // buffer writes stay inside the current row
  a_pend_in_row: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> ({1'b0, pend_idx} < xfer_len))
    else $error("row walk index beyond row length");

  // a new result only ever comes out of the finish step
  a_load_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_FINISH))
    else $error("output loaded outside finish");

  // no command is taken while a row walk still has a read in flight
  a_no_accept_mid_walk: assert property (@(posedge clk) disable iff (rst)
    accept |-> (!pend_valid && (cnt <= xfer_len || !walking)))
    else $error("command accepted during row walk");

endmodule
